### sv/uart_tx_number_printer_assert.svh
// Assertion macros shared by the serial number printer modules.
// No dependencies; included by the files that carry assertions.
`ifndef UART_TX_NUMBER_PRINTER_ASSERT_SVH
`define UART_TX_NUMBER_PRINTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define UTNP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define UTNP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/utnp_pkg.sv
// Types, codes and constants of the serial number printer.
// No dependencies; used by the request channel interface and every module.
`timescale 1ns / 1ps

package utnp_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int VALUE_W    = 32;
   localparam int DCOUNT_W   = 4;
   localparam int CSR_W      = 16;
   localparam int TICK_W     = 17;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W      = 4 * BCD_DIGITS;

   localparam logic [REQ_TYPE_W-1:0] REQ_TICK = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_RAW  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_DEC  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_HEX  = 2'd3;

   localparam logic [CSR_W-1:0] BIT_TICKS_RESET = 16'd104;

   // frame positions: idle, start bit, data bits, stop period
   localparam logic [3:0] FRAME_IDLE      = 4'd0;
   localparam logic [3:0] FRAME_START     = 4'd1;
   localparam logic [3:0] FRAME_LAST_DATA = 4'd9;
   localparam logic [3:0] FRAME_STOP      = 4'd10;

   localparam logic [3:0] HEX_DIGITS  = 4'd8;
   localparam logic [3:0] DEC_DIGITS  = 4'd10;
   localparam logic [4:0] DD_LAST     = 5'd31;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_TICK,
      OP_REJECT,
      OP_RAW,
      OP_DEC_LOAD,
      OP_HEX_LOAD,
      OP_DBL,
      OP_DEC_EMIT,
      OP_HEX_EMIT,
      OP_START,
      OP_RESULT
   } dp_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DBL,
      S_DEC_EMIT,
      S_HEX_EMIT,
      S_START,
      S_RESULT
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic dbl_last;
      logic emit_last;
      logic hex_empty;
   } dp_status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'b0000, nib};
      end else begin
         c = CHAR_A + {4'b0000, nib} - 8'd10;
      end
      return c;
   endfunction

endpackage

### sv/utnp_channels.sv
// Valid/ready channel interfaces for requests and results.
// Depends on utnp_pkg for the field widths.
`timescale 1ns / 1ps

interface utnp_req_if;
   import utnp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [VALUE_W-1:0]    value;
   logic [DCOUNT_W-1:0]   digit_count;

   modport source (output valid, output req_type, output value, output digit_count,
                   input ready);
   modport sink   (input valid, input req_type, input value, input digit_count,
                   output ready);
endinterface

interface utnp_rsp_if;
   logic valid;
   logic ready;
   logic txd_level;
   logic busy_res;
   logic rejected;

   modport source (output valid, output txd_level, output busy_res, output rejected,
                   input ready);
   modport sink   (input valid, input txd_level, input busy_res, input rejected,
                   output ready);
endinterface

### sv/utnp_ctrl.sv
// Sequencer of the serial number printer: decodes requests, steps the
// datapath through conversion and framing, owns the result valid flag.
// Depends on utnp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "uart_tx_number_printer_assert.svh"

module utnp_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [utnp_pkg::REQ_TYPE_W-1:0] req_type,
   output logic                            req_ready,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output utnp_pkg::dp_cmd_type            cmd,
   input  utnp_pkg::dp_status_type         status
);
   import utnp_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_TICK || status.busy) begin
                  state_in = S_RESULT;
               end else if (req_type == REQ_RAW) begin
                  state_in = S_START;
               end else if (req_type == REQ_DEC) begin
                  state_in = S_DBL;
               end else if (status.hex_empty) begin
                  state_in = S_START;
               end else begin
                  state_in = S_HEX_EMIT;
               end
            end
         end
         S_DBL: begin
            if (status.dbl_last) state_in = S_DEC_EMIT;
         end
         S_DEC_EMIT, S_HEX_EMIT: begin
            if (status.emit_last) state_in = S_START;
         end
         S_START: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type != REQ_TICK && status.busy) begin
                  cmd.op = OP_REJECT;
               end else begin
                  unique case (req_type)
                     REQ_TICK: cmd.op = OP_TICK;
                     REQ_RAW:  cmd.op = OP_RAW;
                     REQ_DEC:  cmd.op = OP_DEC_LOAD;
                     REQ_HEX:  cmd.op = OP_HEX_LOAD;
                     default:  cmd.op = OP_NONE;
                  endcase
               end
            end
         end
         S_DBL:      cmd.op = OP_DBL;
         S_DEC_EMIT: cmd.op = OP_DEC_EMIT;
         S_HEX_EMIT: cmd.op = OP_HEX_EMIT;
         S_START:    cmd.op = OP_START;
         S_RESULT: begin
            if (slot_free) cmd.op = OP_RESULT;
         end
         default:    cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_RESULT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `UTNP_ASSERT_IMP(a_rsp_from_result, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_RESULT), "result raised outside result state")
   `UTNP_ASSERT_NXT(a_one_request_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken in back-to-back cycles")
   `UTNP_ASSERT_NXT(a_dbl_runs_to_end, clock, reset, state_ff == S_DBL && !status.dbl_last, state_ff == S_DBL, "decimal conversion cut short")

endmodule

### sv/utnp_dpath.sv
// Datapath of the serial number printer: character queue, decimal and hex
// conversion, 8N2 frame timing and the result register.
// Depends on utnp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "uart_tx_number_printer_assert.svh"

module utnp_dpath #(
   parameter int MAX_CHARS = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   input  utnp_pkg::dp_cmd_type            cmd,
   output utnp_pkg::dp_status_type         status,
   input  logic [utnp_pkg::VALUE_W-1:0]    req_value,
   input  logic [utnp_pkg::DCOUNT_W-1:0]   req_digit_count,
   input  logic                            csr_we,
   input  logic [utnp_pkg::CSR_W-1:0]      csr_wdata,
   output logic                            rsp_txd_level,
   output logic                            rsp_busy_res,
   output logic                            rsp_rejected
);
   import utnp_pkg::*;

   localparam int IDX_W = $clog2(MAX_CHARS);
   localparam int CNT_W = $clog2(MAX_CHARS + 1);

   // configuration and line state
   logic [CSR_W-1:0]  bit_ticks_ff;
   logic              line_ff, line_in;
   logic [TICK_W-1:0] tc_ff, tc_in;
   logic [3:0]        fp_ff, fp_in;
   logic [7:0]        shift_ff, shift_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [IDX_W-1:0]  qi_ff, qi_in;
   logic              rej_ff, rej_in;

   // conversion state
   logic [7:0]         queue_ff [MAX_CHARS];
   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [4:0]         step_ff, step_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [CNT_W-1:0]   wr_ff, wr_in;
   logic               started_ff, started_in;

   logic               q_we;
   logic [IDX_W-1:0]   q_waddr;
   logic [7:0]         q_wdata;
   logic [IDX_W-1:0]   rd_idx;
   logic [7:0]         rd_data_ff;

   logic               txd_ff, busy_ff, rej_out_ff;

   logic [3:0]         hex_cnt;
   logic [3:0]         hex_shift;

   assign hex_cnt   = (req_digit_count > HEX_DIGITS) ? HEX_DIGITS : req_digit_count;
   assign hex_shift = HEX_DIGITS - hex_cnt;

   assign status.busy      = (left_ff != '0);
   assign status.dbl_last  = (step_ff == DD_LAST);
   assign status.emit_last = (cnt_ff == 4'd1);
   assign status.hex_empty = (hex_cnt == 4'd0);

   // idle: keep the first character fetched; sending: the one after the current
   assign rd_idx = (left_ff == '0) ? '0 : qi_ff + 1'b1;

   // conversion and queue fill
   always_comb begin
      logic [BCD_W-1:0] adj;
      logic [3:0]       nib;
      logic [3:0]       top;
      logic             emit;

      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      step_in    = step_ff;
      cnt_in     = cnt_ff;
      wr_in      = wr_ff;
      started_in = started_ff;
      rej_in     = rej_ff;
      q_we       = 1'b0;
      q_waddr    = wr_ff[IDX_W-1:0];
      q_wdata    = 8'h00;
      adj        = bcd_ff;
      top        = bcd_ff[BCD_W-1 -: 4];
      emit       = 1'b0;
      nib        = 4'd0;

      case (cmd.op)
         OP_TICK: begin
            rej_in = 1'b0;
         end
         OP_REJECT: begin
            rej_in = 1'b1;
         end
         OP_RAW: begin
            rej_in  = 1'b0;
            q_we    = 1'b1;
            q_waddr = '0;
            q_wdata = req_value[7:0];
            wr_in   = CNT_W'(1);
         end
         OP_DEC_LOAD: begin
            rej_in     = 1'b0;
            bin_in     = req_value[VALUE_W-1] ? (~req_value + 32'd1) : req_value;
            bcd_in     = '0;
            step_in    = '0;
            cnt_in     = DEC_DIGITS;
            started_in = 1'b0;
            q_we       = req_value[VALUE_W-1];
            q_waddr    = '0;
            q_wdata    = CHAR_MINUS;
            wr_in      = req_value[VALUE_W-1] ? CNT_W'(1) : '0;
         end
         OP_HEX_LOAD: begin
            rej_in = 1'b0;
            bin_in = req_value << {hex_shift, 2'b00};
            cnt_in = hex_cnt;
            wr_in  = '0;
         end
         OP_DBL: begin
            // double dabble: add 3 to every digit of 5 or more, then shift
            for (int i = 0; i < BCD_DIGITS; i++) begin
               nib = bcd_ff[i*4 +: 4];
               adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
            end
            bcd_in  = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
            bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
            step_in = step_ff + 5'd1;
         end
         OP_DEC_EMIT: begin
            // leading zeros dropped, a lone zero kept
            emit       = (top != 4'd0) || started_ff || (cnt_ff == 4'd1);
            q_we       = emit;
            q_wdata    = CHAR_ZERO + {4'b0000, top};
            wr_in      = emit ? wr_ff + 1'b1 : wr_ff;
            started_in = started_ff || emit;
            bcd_in     = {bcd_ff[BCD_W-5:0], 4'b0000};
            cnt_in     = cnt_ff - 4'd1;
         end
         OP_HEX_EMIT: begin
            q_we    = 1'b1;
            q_wdata = hex_char(bin_ff[VALUE_W-1 -: 4]);
            wr_in   = wr_ff + 1'b1;
            bin_in  = {bin_ff[VALUE_W-5:0], 4'b0000};
            cnt_in  = cnt_ff - 4'd1;
         end
         default: begin
         end
      endcase
   end

   // bit timing and framing
   always_comb begin
      logic [CSR_W-1:0]  bt_eff;
      logic [TICK_W-1:0] dur;
      logic [TICK_W-1:0] tc_inc;
      logic [3:0]        fp_m1;
      logic [CNT_W-1:0]  left_dec;
      logic              start_char;

      line_in    = line_ff;
      tc_in      = tc_ff;
      fp_in      = fp_ff;
      shift_in   = shift_ff;
      left_in    = left_ff;
      qi_in      = qi_ff;
      start_char = 1'b0;
      bt_eff     = (bit_ticks_ff == '0) ? CSR_W'(1) : bit_ticks_ff;
      dur        = (fp_ff == FRAME_STOP) ? {bt_eff, 1'b0} : {1'b0, bt_eff};
      tc_inc     = tc_ff + 1'b1;
      fp_m1      = fp_ff - 4'd1;
      left_dec   = (left_ff != '0) ? left_ff - 1'b1 : left_ff;

      case (cmd.op)
         OP_START: begin
            left_in    = wr_ff;
            qi_in      = '0;
            start_char = (wr_ff != '0);
         end
         OP_TICK: begin
            if (fp_ff != FRAME_IDLE) begin
               if (tc_inc < dur) begin
                  tc_in = tc_inc;
               end else begin
                  tc_in = '0;
                  if (fp_ff < FRAME_LAST_DATA) begin
                     line_in = shift_ff[fp_m1[2:0]];
                     fp_in   = fp_ff + 4'd1;
                  end else if (fp_ff == FRAME_LAST_DATA) begin
                     line_in = 1'b1;
                     fp_in   = FRAME_STOP;
                  end else begin
                     // end of stop period: next character or idle
                     line_in    = 1'b1;
                     fp_in      = FRAME_IDLE;
                     left_in    = left_dec;
                     qi_in      = qi_ff + 1'b1;
                     start_char = (left_dec != '0);
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (start_char) begin
         shift_in = rd_data_ff;
         fp_in    = FRAME_START;
         tc_in    = '0;
         line_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff <= BIT_TICKS_RESET;
         line_ff      <= 1'b1;
         tc_ff        <= '0;
         fp_ff        <= FRAME_IDLE;
         left_ff      <= '0;
         qi_ff        <= '0;
         rej_ff       <= 1'b0;
         wr_ff        <= '0;
      end else begin
         if (csr_we) bit_ticks_ff <= csr_wdata;
         line_ff <= line_in;
         tc_ff   <= tc_in;
         fp_ff   <= fp_in;
         left_ff <= left_in;
         qi_ff   <= qi_in;
         rej_ff  <= rej_in;
         wr_ff   <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      step_ff    <= step_in;
      cnt_ff     <= cnt_in;
      started_ff <= started_in;
      if (q_we) queue_ff[q_waddr] <= q_wdata;
      // a character stored this cycle is passed straight to the read register
      if (q_we && q_waddr == rd_idx) begin
         rd_data_ff <= q_wdata;
      end else begin
         rd_data_ff <= (int'(rd_idx) < MAX_CHARS) ? queue_ff[rd_idx] : 8'h00;
      end
      if (cmd.op == OP_RESULT) begin
         txd_ff     <= line_ff;
         busy_ff    <= (left_ff != '0);
         rej_out_ff <= rej_ff;
      end
   end

   assign rsp_txd_level = txd_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_rejected  = rej_out_ff;

   `UTNP_ASSERT_IMP(a_frame_in_range, clock, reset, 1'b1, fp_ff <= FRAME_STOP, "frame position out of range")
   `UTNP_ASSERT_IMP(a_idle_line_high, clock, reset, left_ff == '0, fp_ff == FRAME_IDLE && line_ff, "line not idle with queue empty")
   `UTNP_ASSERT_IMP(a_busy_has_frame, clock, reset, left_ff != '0, fp_ff != FRAME_IDLE, "characters pending but no frame running")

endmodule

### sv/uart_tx_number_printer.sv
// Channel  | Dir | Carries
// req_ch   | in  | req_type, value, digit_count (tick or print request)
// rsp_ch   | out | txd_level, busy_res, rejected (one per request)
// csr_*    | in  | bit period write
//
// Ticks and rejects go straight to the result, a raw byte straight to start;
// hex emits digits; signed decimal runs the 32-step double-dabble, then emits.
// One request is in work at a time; the result register lets the next one be
// taken while the previous result waits on rsp_ch.ready.
// Reset is synchronous; the line comes up high with nothing queued.
// Top level of the serial number printer; depends on utnp_pkg, the channel
// interfaces, utnp_ctrl and utnp_dpath.
`timescale 1ns / 1ps

module uart_tx_number_printer #(
   parameter int MAX_CHARS = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   utnp_req_if.sink                    req_ch,
   utnp_rsp_if.source                  rsp_ch,
   input  logic                        csr_we,
   input  logic [utnp_pkg::CSR_W-1:0]  csr_wdata
);
   import utnp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;
   logic          txd_level;
   logic          busy_res;
   logic          rejected;

   utnp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   utnp_dpath #(
      .MAX_CHARS (MAX_CHARS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_value       (req_ch.value),
      .req_digit_count (req_ch.digit_count),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_txd_level   (txd_level),
      .rsp_busy_res    (busy_res),
      .rsp_rejected    (rejected)
   );

   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_valid;
   assign rsp_ch.txd_level = txd_level;
   assign rsp_ch.busy_res  = busy_res;
   assign rsp_ch.rejected  = rejected;

endmodule
